FILE: src/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants of the tilt angle core
// Holds the controller command struct, fixed-point constants and the
// arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package atrp_pkg;

    localparam int ZW          = 24;        // Q3.20 angle width
    localparam int STEP_W      = 5;         // CORDIC step index width
    localparam int WEIGHT_W    = 16;
    localparam int ROLL_W      = 15;
    localparam int PITCH_W     = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic signed [ZW-1:0]       HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [25:0]         DEG128_SCALE = 26'sd30039490;
    localparam logic signed [18:0]         ROLL_LIMIT  = 19'sd11520;
    localparam logic signed [18:0]         PITCH_LIMIT = 19'sd23040;
    localparam logic [WEIGHT_W-1:0]        WEIGHT_RESET = 16'd64881;

    typedef struct packed {
        logic              square;
        logic              root_init;
        logic              root_step;
        logic              cordic_init;
        logic              cordic_pitch;
        logic              cordic_step;
        logic              save_roll;
        logic              filt_mul;
        logic              filt_add;
        logic              conv_mul;
        logic              conv_out;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic zero_vec;
        logic vertical;
    } stat_t;

    function automatic logic signed [ZW-1:0] atan_q20(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            5'd21:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/atrp_ctrl.sv
// ----------------------------------------------------------------------------
// atrp_ctrl: sequencer of the tilt angle core
// Steps the datapath through squaring, square root, two CORDIC passes,
// filtering and output conversion, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_ctrl #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire atrp_pkg::stat_t stat,
    output atrp_pkg::cmd_t     cmd
);

    localparam int ROOT_N  = SAMPLE_BITS + 8;
    localparam int CNT_MAX = (ROOT_N > CORDIC_STEPS) ? ROOT_N : CORDIC_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_N - 1);
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        IDLE, SQUARE, ROOT_INIT, ROOT, ROLL_INIT, ROLL, PITCH_INIT, PITCH,
        FILT_MUL, FILT_ADD, CONV_MUL, CONV_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_fire;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign out_fire  = (state_reg == CONV_OUT) && (!out_valid_reg || out_ready);

    always_comb begin
        cmd              = '0;
        cmd.step         = cnt_reg[atrp_pkg::STEP_W-1:0];
        cmd.square       = (state_reg == SQUARE);
        cmd.root_init    = (state_reg == ROOT_INIT);
        cmd.root_step    = (state_reg == ROOT);
        cmd.cordic_init  = (state_reg == ROLL_INIT) ||
                           ((state_reg == PITCH_INIT) && !stat.vertical);
        cmd.cordic_pitch = (state_reg == PITCH_INIT);
        cmd.cordic_step  = (state_reg == ROLL) || (state_reg == PITCH);
        cmd.save_roll    = (state_reg == PITCH_INIT);
        cmd.filt_mul     = (state_reg == FILT_MUL);
        cmd.filt_add     = (state_reg == FILT_ADD);
        cmd.conv_mul     = (state_reg == CONV_MUL);
        cmd.conv_out     = out_fire;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            IDLE: begin
                if (in_valid) begin
                    state_next = SQUARE;
                end
            end
            SQUARE: begin
                state_next = stat.zero_vec ? CONV_MUL : ROOT_INIT;
            end
            ROOT_INIT: begin
                state_next = ROOT;
                cnt_next   = '0;
            end
            ROOT: begin
                if (cnt_reg == ROOT_LAST) begin
                    state_next = ROLL_INIT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ROLL_INIT: begin
                state_next = ROLL;
            end
            ROLL: begin
                if (cnt_reg == CORD_LAST) begin
                    state_next = PITCH_INIT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PITCH_INIT: begin
                state_next = stat.vertical ? FILT_MUL : PITCH;
            end
            PITCH: begin
                if (cnt_reg == CORD_LAST) begin
                    state_next = FILT_MUL;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FILT_MUL: begin
                state_next = FILT_ADD;
            end
            FILT_ADD: begin
                state_next = CONV_MUL;
            end
            CONV_MUL: begin
                state_next = CONV_OUT;
            end
            CONV_OUT: begin
                if (out_fire) begin
                    state_next     = IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fire_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |=> out_valid_reg)
        else $error("result not presented after conversion");

    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ROOT) |-> (cnt_reg <= ROOT_LAST))
        else $error("root counter out of range");

    a_cordic_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ROLL) || (state_reg == PITCH)) |-> (cnt_reg <= CORD_LAST))
        else $error("CORDIC counter out of range");

    a_zero_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == SQUARE) && stat.zero_vec) |=> (state_reg == CONV_MUL))
        else $error("zero vector did not bypass the angle computation");

endmodule

`default_nettype wire

FILE: src/atrp_dp.sv
// ----------------------------------------------------------------------------
// atrp_dp: datapath of the tilt angle core
// Sample registers, bitwise square root, shared CORDIC vectoring unit,
// low-pass filter state and degree conversion with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_dp #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic signed [SAMPLE_BITS-1:0]  accel_first,
    input  wire logic signed [SAMPLE_BITS-1:0]  accel_second,
    input  wire logic signed [SAMPLE_BITS-1:0]  accel_third,
    input  wire logic                           cfg_wr_en,
    input  wire logic [atrp_pkg::WEIGHT_W-1:0]  cfg_wr_data,
    input  wire atrp_pkg::cmd_t                 cmd,
    output atrp_pkg::stat_t                     stat,
    output logic signed [atrp_pkg::ROLL_W-1:0]  roll_angle,
    output logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle,
    output logic                                status
);

    localparam int S   = SAMPLE_BITS;
    localparam int NW  = 2 * S + 16;
    localparam int RSW = S + 8;
    localparam int RMW = S + 10;
    localparam int CW  = S + 10;
    localparam int ZW  = atrp_pkg::ZW;
    localparam int PW  = 42;
    localparam int AW  = 51;
    localparam int ROLL_W_L = atrp_pkg::ROLL_W;

    logic signed [S-1:0]   ax_reg, ay_reg, az_reg;
    logic                  zero_reg, vert_reg, status_reg;
    logic [2*S-1:0]        sqa_reg, sqz_reg;
    logic [NW-1:0]         n_reg;
    logic [RMW-1:0]        rem_reg;
    logic [RSW-1:0]        res_reg;
    logic signed [CW-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic signed [ZW-1:0]  roll_raw_reg, roll_sm_reg, pitch_sm_reg, pitch_raw;
    logic [atrp_pkg::WEIGHT_W-1:0] weight_reg;
    logic signed [PW-1:0]  pr_old_reg, pr_new_reg, pp_old_reg, pp_new_reg;
    logic signed [AW-2:0]  cr_reg, cp_reg;
    logic signed [ROLL_W_L-1:0] roll_reg;
    logic signed [atrp_pkg::PITCH_W-1:0] pitch_reg;

    // Square root step signals.
    logic [RMW+1:0] rem_sh, trial;
    logic           root_ge;

    // CORDIC operands.
    logic signed [CW-1:0] sx, sy, ix, iy, dx, dy;
    logic signed [ZW-1:0] iz, atan_v;

    // Filter and conversion signals.
    logic signed [17:0]   w_s, wc_s;
    logic signed [PW:0]   acc_r, acc_p;
    logic signed [AW-1:0] dr_full, dp_full;
    logic signed [18:0]   dr, dp, dr_c, dp_c;

    assign stat.zero_vec = zero_reg;
    assign stat.vertical = vert_reg;

    assign rem_sh  = {rem_reg, n_reg[NW-1 -: 2]};
    assign trial   = {2'b00, res_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    always_comb begin
        if (cmd.cordic_pitch) begin
            sx = CW'(az_reg) <<< 8;
            sy = CW'(ax_reg) <<< 8;
        end else begin
            sx = CW'({1'b0, res_reg});
            sy = -(CW'(ay_reg) <<< 8);
        end
        ix = sx;
        iy = sy;
        iz = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                ix = sy;
                iy = -sx;
                iz = atrp_pkg::HALF_PI_Q20;
            end else begin
                ix = -sy;
                iy = sx;
                iz = -atrp_pkg::HALF_PI_Q20;
            end
        end
    end

    assign dx     = y_reg >>> cmd.step;
    assign dy     = x_reg >>> cmd.step;
    assign atan_v = atrp_pkg::atan_q20(cmd.step);

    always_comb begin
        if (y_reg >= 0) begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_v;
        end else begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_v;
        end
    end

    // Pitch is taken straight from the CORDIC angle unless the vector is vertical.
    assign pitch_raw = vert_reg ? '0 : z_reg;
    assign w_s       = 18'({1'b0, weight_reg});
    assign wc_s      = 18'sd65536 - w_s;

    assign acc_r = PW'(pr_old_reg) + PW'(pr_new_reg) + (PW+1)'(32768);
    assign acc_p = PW'(pp_old_reg) + PW'(pp_new_reg) + (PW+1)'(32768);

    assign dr_full = AW'(cr_reg) + (AW'(1) <<< 31);
    assign dp_full = AW'(cp_reg) + (AW'(1) <<< 31);
    assign dr      = dr_full[AW-1:32];
    assign dp      = dp_full[AW-1:32];

    always_comb begin
        dr_c = dr;
        if (dr > atrp_pkg::ROLL_LIMIT) dr_c = atrp_pkg::ROLL_LIMIT;
        if (dr < -atrp_pkg::ROLL_LIMIT) dr_c = -atrp_pkg::ROLL_LIMIT;
        dp_c = dp;
        if (dp > atrp_pkg::PITCH_LIMIT) dp_c = atrp_pkg::PITCH_LIMIT;
        if (dp < -atrp_pkg::PITCH_LIMIT) dp_c = -atrp_pkg::PITCH_LIMIT;
    end

    // Control-like state: filter memory and the weight register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_sm_reg  <= '0;
            pitch_sm_reg <= '0;
            weight_reg   <= atrp_pkg::WEIGHT_RESET;
        end else begin
            if (cfg_wr_en) begin
                weight_reg <= cfg_wr_data;
            end
            if (cmd.filt_add) begin
                roll_sm_reg  <= acc_r[16 +: ZW];
                pitch_sm_reg <= acc_p[16 +: ZW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ax_reg   <= accel_third;
            ay_reg   <= accel_first;
            az_reg   <= accel_second;
            zero_reg <= (accel_first == '0) && (accel_second == '0) &&
                        (accel_third == '0);
            vert_reg <= (accel_second == '0) && (accel_third == '0);
        end
        if (cmd.square) begin
            sqa_reg <= (2*S)'(ax_reg * ax_reg);
            sqz_reg <= (2*S)'(az_reg * az_reg);
        end
        if (cmd.root_init) begin
            n_reg   <= NW'(sqa_reg + sqz_reg) << 16;
            rem_reg <= '0;
            res_reg <= '0;
        end
        if (cmd.root_step) begin
            n_reg   <= n_reg << 2;
            rem_reg <= root_ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
            res_reg <= {res_reg[RSW-2:0], root_ge};
        end
        if (cmd.cordic_init) begin
            x_reg <= ix;
            y_reg <= iy;
            z_reg <= iz;
        end
        if (cmd.cordic_step) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (cmd.save_roll) begin
            roll_raw_reg <= z_reg;
        end
        if (cmd.filt_mul) begin
            pr_old_reg <= PW'(w_s * roll_sm_reg);
            pr_new_reg <= PW'(wc_s * roll_raw_reg);
            pp_old_reg <= PW'(w_s * pitch_sm_reg);
            pp_new_reg <= PW'(wc_s * pitch_raw);
        end
        if (cmd.conv_mul) begin
            cr_reg <= (AW-1)'(roll_sm_reg * atrp_pkg::DEG128_SCALE);
            cp_reg <= (AW-1)'(pitch_sm_reg * atrp_pkg::DEG128_SCALE);
        end
        if (cmd.conv_out) begin
            roll_reg   <= dr_c[ROLL_W_L-1:0];
            pitch_reg  <= dp_c[atrp_pkg::PITCH_W-1:0];
            status_reg <= zero_reg;
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

FILE: src/accel_tilt_roll_pitch_lpf_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_lpf_core: accelerometer roll and pitch with low-pass
// Turns three-axis accelerometer samples into smoothed roll and pitch angles.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_axis channel carries one accelerometer sample. The
// axes are remapped (x from the third element, y from the first, z from the
// second). Roll is atan2(-y, sqrt(x*x + z*z)) and pitch is atan2(x, z), both
// from one shared iterative CORDIC unit and held in Q3.20 radians. Each angle
// passes a first-order low-pass filter whose previous-value weight is set
// through cfg_wr_en/cfg_wr_data. Each sample gives one transfer on m_axis with
// the filtered angles in 1/128 degree and a status flag in tuser.
// An ordinary sample passes through the bitwise square root loop and the two
// CORDIC passes between its transfer and its result. A vertical sample (x and
// z both zero) skips the pitch pass. One sample is in work at a time; the
// next transfer is taken once the result has been loaded into the output
// register, so a new sample is not taken while the last one is still in work.
// An all-zero sample skips the computation, reports status 1 and returns the
// held angles without touching the filter state.
// Reset clears the filter state to zero and sets the weight to 64881 (0.99).
// When the receiver stalls, the result stays in the output register; the next
// sample is still accepted and computed, and waits before its conversion
// until the pending result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_roll_pitch_lpf_core #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // accel_first, accel_second, accel_third from bit 0 up, zero padded
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // roll_angle [14:0], pitch_angle [30:15], zero in bit 31
    output logic [atrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic                             m_axis_tuser,
    input  wire logic                        cfg_wr_en,
    input  wire logic [atrp_pkg::WEIGHT_W-1:0] cfg_wr_data
);

    localparam int S = SAMPLE_BITS;

    atrp_pkg::cmd_t  cmd;
    atrp_pkg::stat_t stat;
    logic            load;
    logic signed [atrp_pkg::ROLL_W-1:0]  roll_angle;
    logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle;
    logic            status;

    // A sample is captured on the transfer itself.
    assign load = s_axis_tvalid && s_axis_tready;

    atrp_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    atrp_dp #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .accel_first (s_axis_tdata[S-1:0]),
        .accel_second(s_axis_tdata[2*S-1:S]),
        .accel_third (s_axis_tdata[3*S-1:2*S]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .status      (status)
    );

    assign m_axis_tdata = {1'b0, pitch_angle, roll_angle};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire
